### hw/rtl/bda_pkg.sv
// shared types and constants for the binary to decimal ascii converter
// no dependencies; used by bda_digit_cell and binary_to_decimal_ascii_core

package bda_pkg;

  localparam int VALUE_WIDTH = 32;
  // decimal digits needed for VALUE_WIDTH bits: floor(w * log10(2)) + 1
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int IN_BYTES    = (VALUE_WIDTH + 7) / 8;
  localparam int IN_TDATA_W  = IN_BYTES * 8;
  localparam int CHAR_W      = 6;
  localparam int OUT_TDATA_W = 8;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } bda_state_t;

  // per-cycle command broadcast to every digit cell
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correction then shift in carry from below
    logic shift;   // take the digit of the lower neighbor
  } bda_cell_ctrl_t;

endpackage

### hw/rtl/binary_to_decimal_ascii_core.sv
// top level: binary value in, decimal ascii digit words out, msd first
// depends on bda_pkg and bda_digit_cell
//
//  channel | dir | tdata                        | tlast
//  --------+-----+------------------------------+--------------------------
//  in_     | in  | [31:0] value                 | -
//  out_    | out | [5:0] digit_char, [7:6] zero | last (least signif. digit)
//
// one value at a time: a load, then double-dabble of all VALUE_WIDTH bits
// through the chain of NUM_DIGITS digit cells, then NUM_DIGITS shifts of the
// chain toward the output; leading zeros are skipped without an output word,
// and real digits wait while out_tready stays low.
// rst_n is synchronous, active low, and returns the sequencer to idle.
// a stalled output word holds: the chain does not move until it is taken.

module binary_to_decimal_ascii_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bda_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bda_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [5:0] digit_char
  output logic                              out_tlast
);

  localparam int W  = bda_pkg::VALUE_WIDTH;
  localparam int ND = bda_pkg::NUM_DIGITS;

  bda_pkg::bda_state_t              state_r, state_nxt;
  logic [W-1:0]                     bin_r, bin_nxt;
  logic [bda_pkg::BIT_CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [bda_pkg::DIG_CNT_W-1:0]    remain_r, remain_nxt;
  logic                             lead_r, lead_nxt;

  bda_pkg::bda_cell_ctrl_t          cell_ctrl;
  logic                             cell_carry [ND];
  logic [3:0]                       cell_digit [ND];

  logic                             in_fire;
  logic                             out_fire;
  logic                             last_slot;   // only the units digit is left
  logic                             show;        // top digit is a real digit
  logic [3:0]                       top_digit;
  logic [bda_pkg::CHAR_W-1:0]       digit_char;

  // chain of digit cells, cell 0 is the units digit
  for (genvar i = 0; i < ND; i++) begin : g_cell
    if (i == 0) begin : g_first
      bda_digit_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .carry_in  (bin_r[W-1]),
        .digit_in  (4'd0),
        .carry_out (cell_carry[i]),
        .digit     (cell_digit[i])
      );
    end else begin : g_rest
      bda_digit_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .carry_in  (cell_carry[i-1]),
        .digit_in  (cell_digit[i-1]),
        .carry_out (cell_carry[i]),
        .digit     (cell_digit[i])
      );
    end
  end

  assign top_digit  = cell_digit[ND-1];
  assign last_slot  = (remain_r == bda_pkg::DIG_CNT_W'(1));
  assign show       = !lead_r || (top_digit != 4'd0) || last_slot;
  assign digit_char = bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(top_digit);

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bda_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = bda_pkg::ST_CONVERT;
        end
      end
      bda_pkg::ST_CONVERT: begin
        if (bit_cnt_r == '0) begin
          state_nxt = bda_pkg::ST_EMIT;
        end
      end
      bda_pkg::ST_EMIT: begin
        if (last_slot && out_tready) begin
          state_nxt = bda_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bda_pkg::ST_IDLE;
    endcase
  end

  // outputs and cell commands
  always_comb begin
    in_tready        = 1'b0;
    out_tvalid       = 1'b0;
    cell_ctrl.clear  = 1'b0;
    cell_ctrl.dabble = 1'b0;
    cell_ctrl.shift  = 1'b0;
    unique case (state_r)
      bda_pkg::ST_IDLE: begin
        in_tready       = 1'b1;
        cell_ctrl.clear = 1'b1;
      end
      bda_pkg::ST_CONVERT: begin
        cell_ctrl.dabble = 1'b1;
      end
      bda_pkg::ST_EMIT: begin
        out_tvalid = show;
        // leading zeros drop out silently, real digits move when taken
        cell_ctrl.shift = !show || out_tready;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign out_tdata = {(bda_pkg::OUT_TDATA_W - bda_pkg::CHAR_W)'(0), digit_char};
  assign out_tlast = last_slot;

  // datapath counters and binary shift register
  always_comb begin
    bin_nxt     = bin_r;
    bit_cnt_nxt = bit_cnt_r;
    remain_nxt  = remain_r;
    lead_nxt    = lead_r;
    if (in_fire) begin
      bin_nxt     = in_tdata[W-1:0];
      bit_cnt_nxt = bda_pkg::BIT_CNT_W'(W - 1);
    end else if (cell_ctrl.dabble) begin
      bin_nxt     = {bin_r[W-2:0], 1'b0};
      bit_cnt_nxt = bit_cnt_r - bda_pkg::BIT_CNT_W'(1);
      remain_nxt  = bda_pkg::DIG_CNT_W'(ND);
      lead_nxt    = 1'b1;
    end else if (cell_ctrl.shift) begin
      remain_nxt = remain_r - bda_pkg::DIG_CNT_W'(1);
      if (out_fire) begin
        lead_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    remain_r  <= remain_nxt;
    lead_r    <= lead_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/bda_digit_cell.sv
// one bcd digit cell of the double-dabble chain
// depends on bda_pkg for the cell command struct

module bda_digit_cell (
  input  logic                     clk,
  input  bda_pkg::bda_cell_ctrl_t  ctrl,
  input  logic                     carry_in,   // msb of the lower neighbor after add-3
  input  logic [3:0]               digit_in,   // digit of the lower neighbor
  output logic                     carry_out,
  output logic [3:0]               digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  end

  always_comb begin
    if (ctrl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[2:0], carry_in};
    end else if (ctrl.shift) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign carry_out = adj[3];
  assign digit     = digit_r;

endmodule
